>>> src/srs_pkg.sv
// Shared constants, types and functions of the scan range to rotated segments block.
`default_nettype none
package srs_pkg;

	localparam int POINTS_PER_SCAN = 1080;

	localparam int IDX_W = 12;
	localparam int CNT_W = 13;
	localparam int RANGE_W = 16;
	localparam int JUMP_W = 8;
	localparam int COORD_W = 17;
	localparam int COEF_W = 16;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_FRACTION = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_XX = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_XY = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_YX = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_YY = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ZX = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ZY = 4'd7;

	localparam int ANG_SPAN = 4941298;
	localparam int ANG_START = 2470649;
	localparam int ANG_LIMIT = 1647099;
	localparam int ANG_PI = 3294199;
	localparam int STEP_Q = ANG_SPAN / POINTS_PER_SCAN;
	localparam int STEP_R = ANG_SPAN % POINTS_PER_SCAN;
	localparam int HALF_N = POINTS_PER_SCAN / 2;
	localparam int PHASE_W = 23;
	localparam int REM_W = 12;
	localparam int ANG_W = 24;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_W = 31;
	localparam int CORDIC_X0 = 163008219;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic signed [COEF_W-1:0] xx;
		logic signed [COEF_W-1:0] xy;
		logic signed [COEF_W-1:0] yx;
		logic signed [COEF_W-1:0] yy;
		logic signed [COEF_W-1:0] zx;
		logic signed [COEF_W-1:0] zy;
	} rot_cfg_t;

	typedef struct packed {
		logic keep;
		logic start;
		logic last;
		logic [IDX_W-1:0] idx;
		logic [RANGE_W-1:0] range;
		logic [CNT_W-1:0] cnt;
		logic [PHASE_W-1:0] phase;
	} srs_item_t;

	typedef struct packed {
		logic keep;
		logic start;
		logic last;
		logic neg;
		logic [IDX_W-1:0] idx;
		logic [RANGE_W-1:0] range;
		logic [CNT_W-1:0] cnt;
	} srs_side_t;

	function automatic logic signed [ANG_W-1:0] cordic_atan(input int k);
		logic signed [ANG_W-1:0] r;
		case (k)
			0: r = 24'sd823550;
			1: r = 24'sd486170;
			2: r = 24'sd256879;
			3: r = 24'sd130396;
			4: r = 24'sd65451;
			5: r = 24'sd32757;
			6: r = 24'sd16383;
			7: r = 24'sd8192;
			8: r = 24'sd4096;
			9: r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/scan_range_to_rotated_segments.sv
// Top level: configuration registers and the front, queue and back of the block.
// Each input item is one range sample (range_mm, scan_last) on the in_valid/in_ready
// channel. A sample nearer than near_limit_mm is dropped and counted; every other
// sample gives one world point on the out_valid/out_ready channel, and the last
// sample of a scan also gives an end of scan marker carrying the drop count.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high and unknown indexes are ignored. The beam angle is
// produced by a 16-stage CORDIC pipeline followed by four multiply and rounding
// stages, so one sample can enter every cycle unless the output stalls; a sample
// that gives a point and a marker holds the back end while the marker goes out.
// A four-entry queue separates the front from the back: when out_ready is low the
// back end freezes in place, the queue fills, and then in_ready falls.
// Reset clears the scan position, the drop count and all pipeline valid bits, and
// loads the register defaults; the block is ready in the first cycle after reset.
`default_nettype none
module scan_range_to_rotated_segments (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [srs_pkg::RANGE_W-1:0] range_mm,
	input  logic scan_last,
	output logic out_valid,
	input  logic out_ready,
	output logic kind,
	output logic signed [srs_pkg::COORD_W-1:0] world_x,
	output logic signed [srs_pkg::COORD_W-1:0] world_y,
	output logic signed [srs_pkg::COORD_W-1:0] world_z,
	output logic segment_start,
	output logic [srs_pkg::IDX_W-1:0] beam_index,
	output logic [srs_pkg::CNT_W-1:0] too_close_count,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [srs_pkg::RANGE_W-1:0] near_limit_q;
	logic [srs_pkg::JUMP_W-1:0] jump_fraction_q;
	srs_pkg::rot_cfg_t rot_q;

	logic push;
	logic full;
	logic pop;
	logic empty;
	srs_pkg::srs_item_t wr_item;
	srs_pkg::srs_item_t rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_limit_q <= 16'd100;
			jump_fraction_q <= 8'd128;
			rot_q.xx <= 16'sd16384;
			rot_q.xy <= '0;
			rot_q.yx <= '0;
			rot_q.yy <= 16'sd16384;
			rot_q.zx <= '0;
			rot_q.zy <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				srs_pkg::REG_NEAR_LIMIT: near_limit_q <= cfg_data;
				srs_pkg::REG_JUMP_FRACTION: jump_fraction_q <= cfg_data[srs_pkg::JUMP_W-1:0];
				srs_pkg::REG_ROT_XX: rot_q.xx <= cfg_data;
				srs_pkg::REG_ROT_XY: rot_q.xy <= cfg_data;
				srs_pkg::REG_ROT_YX: rot_q.yx <= cfg_data;
				srs_pkg::REG_ROT_YY: rot_q.yy <= cfg_data;
				srs_pkg::REG_ROT_ZX: rot_q.zx <= cfg_data;
				srs_pkg::REG_ROT_ZY: rot_q.zy <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	srs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.range_mm(range_mm),
		.scan_last(scan_last),
		.near_limit_mm(near_limit_q),
		.jump_fraction(jump_fraction_q),
		.full(full),
		.push(push),
		.item(wr_item)
	);

	srs_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(wr_item),
		.full(full),
		.pop(pop),
		.rd_item(rd_item),
		.empty(empty)
	);

	srs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(rd_item),
		.empty(empty),
		.pop(pop),
		.rot(rot_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.world_x(world_x),
		.world_y(world_y),
		.world_z(world_z),
		.segment_start(segment_start),
		.beam_index(beam_index),
		.too_close_count(too_close_count),
		.last(last)
	);

endmodule
`default_nettype wire

>>> src/srs_fifo.sv
// Small item queue between the front and the back of the block.
`default_nettype none
module srs_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  srs_pkg::srs_item_t wr_item,
	output logic full,
	input  logic pop,
	output srs_pkg::srs_item_t rd_item,
	output logic empty
);

	srs_pkg::srs_item_t mem_q [srs_pkg::FIFO_DEPTH];
	logic [srs_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [srs_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [srs_pkg::FIFO_PTR_W:0] count_q;

	assign full = (count_q == (srs_pkg::FIFO_PTR_W+1)'(srs_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/srs_front.sv
// Front end: takes range samples, tracks the scan state and classifies each item.
`default_nettype none
module srs_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [srs_pkg::RANGE_W-1:0] range_mm,
	input  logic scan_last,
	input  logic [srs_pkg::RANGE_W-1:0] near_limit_mm,
	input  logic [srs_pkg::JUMP_W-1:0] jump_fraction,
	input  logic full,
	output logic push,
	output srs_pkg::srs_item_t item
);

	localparam int RW = srs_pkg::REM_W;

	logic [srs_pkg::IDX_W-1:0] idx_q;
	logic [srs_pkg::PHASE_W-1:0] phase_q;
	logic [RW-1:0] rem_q;
	logic [srs_pkg::RANGE_W-1:0] prev_q;
	logic have_q;
	logic [srs_pkg::CNT_W-1:0] cnt_q;

	logic acc;
	logic drop;
	logic start;
	logic wrap;
	logic carry;
	logic [RW:0] rem_sum;
	logic [RW-1:0] rem_next;
	logic [srs_pkg::PHASE_W-1:0] phase_next;
	logic [srs_pkg::CNT_W-1:0] cnt_next;
	logic [8:0] hi_f;
	logic [8:0] lo_f;
	logic [24:0] d_w;
	logic [24:0] hi_w;
	logic [24:0] lo_w;

	assign in_ready = !full;
	assign acc = in_valid && !full;
	assign drop = (range_mm < near_limit_mm);
	assign push = acc && (!drop || scan_last);

	assign hi_f = 9'd256 + {1'b0, jump_fraction};
	assign lo_f = 9'd256 - {1'b0, jump_fraction};
	assign d_w = {1'b0, range_mm, 8'h00};
	assign hi_w = 25'(prev_q) * 25'(hi_f);
	assign lo_w = 25'(prev_q) * 25'(lo_f);
	assign start = !have_q || (d_w > hi_w) || (d_w < lo_w);

	assign wrap = (idx_q == srs_pkg::IDX_W'(srs_pkg::POINTS_PER_SCAN - 1));
	assign rem_sum = {1'b0, rem_q} + (RW+1)'(srs_pkg::STEP_R);
	assign carry = (rem_sum >= (RW+1)'(srs_pkg::POINTS_PER_SCAN));
	assign rem_next = carry ? RW'(rem_sum - (RW+1)'(srs_pkg::POINTS_PER_SCAN))
		: rem_sum[RW-1:0];
	assign phase_next = phase_q + srs_pkg::PHASE_W'(srs_pkg::STEP_Q)
		+ srs_pkg::PHASE_W'(carry);

	always_comb begin
		cnt_next = cnt_q;
		if (drop && (cnt_q != '1)) begin
			cnt_next = cnt_q + 1'b1;
		end
	end

	always_comb begin
		item.keep = !drop;
		item.start = start;
		item.last = scan_last;
		item.idx = idx_q;
		item.range = range_mm;
		item.cnt = cnt_next;
		item.phase = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			phase_q <= '0;
			rem_q <= RW'(srs_pkg::HALF_N);
			prev_q <= '0;
			have_q <= 1'b0;
			cnt_q <= '0;
		end else if (acc) begin
			if (!drop) begin
				prev_q <= range_mm;
			end
			if (scan_last || wrap) begin
				idx_q <= '0;
				phase_q <= '0;
				rem_q <= RW'(srs_pkg::HALF_N);
			end else begin
				idx_q <= idx_q + 1'b1;
				phase_q <= phase_next;
				rem_q <= rem_next;
			end
			if (scan_last) begin
				cnt_q <= '0;
				have_q <= 1'b0;
			end else begin
				cnt_q <= cnt_next;
				have_q <= have_q || !drop;
			end
		end
	end

endmodule
`default_nettype wire

>>> src/srs_back.sv
// Back end: angle pipeline, rotation multiplies and the result register.
`default_nettype none
module srs_back (
	input  logic clk,
	input  logic arst_n,
	input  srs_pkg::srs_item_t head,
	input  logic empty,
	output logic pop,
	input  srs_pkg::rot_cfg_t rot,
	output logic out_valid,
	input  logic out_ready,
	output logic kind,
	output logic signed [srs_pkg::COORD_W-1:0] world_x,
	output logic signed [srs_pkg::COORD_W-1:0] world_y,
	output logic signed [srs_pkg::COORD_W-1:0] world_z,
	output logic segment_start,
	output logic [srs_pkg::IDX_W-1:0] beam_index,
	output logic [srs_pkg::CNT_W-1:0] too_close_count,
	output logic last
);

	localparam int NS = srs_pkg::CORDIC_STEPS;
	localparam int CW = srs_pkg::CORDIC_W;
	localparam int AW = srs_pkg::ANG_W;
	localparam int QW = srs_pkg::COEF_W;
	localparam int PW = 50;

	function automatic logic signed [QW-1:0] to_q14(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		logic signed [CW-15:0] r;
		logic signed [QW-1:0] o;
		t = v + CW'(8192);
		r = t[CW-1:14];
		if (r > (CW-14)'(16384)) begin
			o = QW'(16384);
		end else if (r < -(CW-14)'(16384)) begin
			o = -QW'(16384);
		end else begin
			o = r[QW-1:0];
		end
		return o;
	endfunction

	function automatic logic signed [srs_pkg::COORD_W-1:0] world_sat(
		input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		logic signed [PW-29:0] r;
		logic signed [srs_pkg::COORD_W-1:0] o;
		t = p + PW'(1 << 27);
		r = t[PW-1:28];
		if (r > (PW-28)'(65535)) begin
			o = srs_pkg::COORD_W'(65535);
		end else if (r < -(PW-28)'(65536)) begin
			o = -srs_pkg::COORD_W'(65536);
		end else begin
			o = r[srs_pkg::COORD_W-1:0];
		end
		return o;
	endfunction

	logic en;
	logic ld_ok;

	logic signed [AW-1:0] ang_w;
	logic signed [AW-1:0] fold_w;
	logic neg_w;
	srs_pkg::srs_side_t side_w;

	logic [NS:0] v_cor_q;
	srs_pkg::srs_side_t sd_cor_q [NS+1];
	logic signed [CW-1:0] cx_q [NS+1];
	logic signed [CW-1:0] cy_q [NS+1];
	logic signed [AW-1:0] cz_q [NS+1];

	logic v_s17, v_s18, v_s19, v_s20;
	srs_pkg::srs_side_t sd_s17, sd_s18, sd_s19, sd_s20;
	logic signed [CW-1:0] xn_w;
	logic signed [CW-1:0] yn_w;
	logic signed [QW-1:0] cos_s17, sin_s17;
	logic signed [31:0] pxx_s18, pxy_s18, pyx_s18, pyy_s18, pzx_s18, pzy_s18;
	logic signed [32:0] mx_s19, my_s19, mz_s19;
	logic signed [PW-1:0] wx_s20, wy_s20, wz_s20;

	logic out_valid_q;
	logic mk_pend_q;
	logic [srs_pkg::IDX_W-1:0] mk_idx_q;
	logic [srs_pkg::CNT_W-1:0] mk_cnt_q;
	logic kind_q;
	logic signed [srs_pkg::COORD_W-1:0] wx_q, wy_q, wz_q;
	logic seg_q;
	logic [srs_pkg::IDX_W-1:0] bidx_q;
	logic [srs_pkg::CNT_W-1:0] cnt_q;
	logic last_q;

	assign ld_ok = !out_valid_q || out_ready;
	assign en = !v_s20 || (ld_ok && !mk_pend_q);
	assign pop = en && !empty;

	always_comb begin
		ang_w = $signed({1'b0, head.phase}) - AW'(srs_pkg::ANG_START);
		fold_w = ang_w;
		neg_w = 1'b0;
		if (ang_w > AW'(srs_pkg::ANG_LIMIT)) begin
			fold_w = ang_w - AW'(srs_pkg::ANG_PI);
			neg_w = 1'b1;
		end else if (ang_w < -AW'(srs_pkg::ANG_LIMIT)) begin
			fold_w = ang_w + AW'(srs_pkg::ANG_PI);
			neg_w = 1'b1;
		end
		side_w.keep = head.keep;
		side_w.start = head.start;
		side_w.last = head.last;
		side_w.neg = neg_w;
		side_w.idx = head.idx;
		side_w.range = head.range;
		side_w.cnt = head.cnt;
	end

	assign xn_w = sd_cor_q[NS].neg ? -cx_q[NS] : cx_q[NS];
	assign yn_w = sd_cor_q[NS].neg ? -cy_q[NS] : cy_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_cor_q <= '0;
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
		end else if (en) begin
			v_cor_q <= {v_cor_q[NS-1:0], pop};
			v_s17 <= v_cor_q[NS];
			v_s18 <= v_s17;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_cor_q[0] <= side_w;
			cx_q[0] <= CW'(srs_pkg::CORDIC_X0);
			cy_q[0] <= '0;
			cz_q[0] <= fold_w;
			for (int k = 0; k < NS; k++) begin
				sd_cor_q[k+1] <= sd_cor_q[k];
				if (!cz_q[k][AW-1]) begin
					cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
					cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
					cz_q[k+1] <= cz_q[k] - srs_pkg::cordic_atan(k);
				end else begin
					cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
					cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
					cz_q[k+1] <= cz_q[k] + srs_pkg::cordic_atan(k);
				end
			end

			sd_s17 <= sd_cor_q[NS];
			cos_s17 <= to_q14(xn_w);
			sin_s17 <= to_q14(yn_w);

			sd_s18 <= sd_s17;
			pxx_s18 <= rot.xx * cos_s17;
			pxy_s18 <= rot.xy * sin_s17;
			pyx_s18 <= rot.yx * cos_s17;
			pyy_s18 <= rot.yy * sin_s17;
			pzx_s18 <= rot.zx * cos_s17;
			pzy_s18 <= rot.zy * sin_s17;

			sd_s19 <= sd_s18;
			mx_s19 <= {pxx_s18[31], pxx_s18} + {pxy_s18[31], pxy_s18};
			my_s19 <= {pyx_s18[31], pyx_s18} + {pyy_s18[31], pyy_s18};
			mz_s19 <= {pzx_s18[31], pzx_s18} + {pzy_s18[31], pzy_s18};

			sd_s20 <= sd_s19;
			wx_s20 <= mx_s19 * $signed({1'b0, sd_s19.range});
			wy_s20 <= my_s19 * $signed({1'b0, sd_s19.range});
			wz_s20 <= mz_s19 * $signed({1'b0, sd_s19.range});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mk_pend_q <= 1'b0;
		end else if (ld_ok) begin
			if (mk_pend_q) begin
				out_valid_q <= 1'b1;
				mk_pend_q <= 1'b0;
			end else if (v_s20) begin
				out_valid_q <= 1'b1;
				mk_pend_q <= sd_s20.keep && sd_s20.last;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ok) begin
			if (mk_pend_q || (v_s20 && !sd_s20.keep)) begin
				kind_q <= 1'b1;
				wx_q <= '0;
				wy_q <= '0;
				wz_q <= '0;
				seg_q <= 1'b0;
				bidx_q <= mk_pend_q ? mk_idx_q : sd_s20.idx;
				cnt_q <= mk_pend_q ? mk_cnt_q : sd_s20.cnt;
				last_q <= 1'b1;
			end else if (v_s20) begin
				kind_q <= 1'b0;
				wx_q <= world_sat(wx_s20);
				wy_q <= world_sat(wy_s20);
				wz_q <= world_sat(wz_s20);
				seg_q <= sd_s20.start;
				bidx_q <= sd_s20.idx;
				cnt_q <= '0;
				last_q <= !sd_s20.last;
			end
			if (!mk_pend_q && v_s20) begin
				mk_idx_q <= sd_s20.idx;
				mk_cnt_q <= sd_s20.cnt;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign world_x = wx_q;
	assign world_y = wy_q;
	assign world_z = wz_q;
	assign segment_start = seg_q;
	assign beam_index = bidx_q;
	assign too_close_count = cnt_q;
	assign last = last_q;

endmodule
`default_nettype wire
